@@ hw/rtl/tea_pkg.sv @@
// Shared types, constants and round functions for the TEA block encryption pipeline.
// No dependencies; every RTL file of the block imports it.
`default_nettype none

package tea_pkg;

   localparam int WORD_WIDTH          = 32;
   localparam int ROUND_COUNT_DEFAULT = 32;
   localparam int CSR_INDEX_WIDTH     = 2;

   localparam logic [WORD_WIDTH-1:0] TEA_DELTA = 32'h9e3779b9;

   localparam logic [WORD_WIDTH-1:0] KEY_WORD_0_RESET = 32'h1;
   localparam logic [WORD_WIDTH-1:0] KEY_WORD_1_RESET = 32'h2;
   localparam logic [WORD_WIDTH-1:0] KEY_WORD_2_RESET = 32'h3;
   localparam logic [WORD_WIDTH-1:0] KEY_WORD_3_RESET = 32'h4;

   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KEY_WORD_0 = 2'd0,
      CSR_KEY_WORD_1 = 2'd1,
      CSR_KEY_WORD_2 = 2'd2,
      CSR_KEY_WORD_3 = 2'd3
   } csr_index_type;

   // One pipeline slot: valid bit travels with the block halves.
   typedef struct packed {
      logic     valid;
      word_type left;
      word_type right;
   } stage_type;

   // Running sum after round r (0-based), wrapped to 32 bits.
   function automatic word_type round_sum(input int unsigned round_index);
      logic [2*WORD_WIDTH-1:0] product;
      product = (2*WORD_WIDTH)'(round_index + 1) * (2*WORD_WIDTH)'(TEA_DELTA);
      return product[WORD_WIDTH-1:0];
   endfunction

   function automatic word_type tea_mix(input word_type half, input word_type sum,
                                        input word_type key_a, input word_type key_b);
      return ((half << 4) + key_a) ^ (half + sum) ^ ((half >> 5) + key_b);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tea_block_encrypt.sv @@
// Top level of the TEA block encryption pipeline: key registers and round stages.
// Depends on tea_pkg and tea_half_round.
//
// Usage:
//   Request channel (req_valid / req_stall, req_plain_left / req_plain_right)
//   carries one 64-bit plaintext block per request. Response channel
//   (rsp_valid / rsp_stall, rsp_cipher_left / rsp_cipher_right) returns one
//   ciphertext block per request, in request order.
//   Each round is split into two registered half-round stages. Throughput
//   is one block per cycle while no response is held by rsp_stall; no
//   state is shared between blocks.
//   The key sits in four registers written through the csr port
//   (csr_write_enable, csr_index, csr_write_data); write only while the
//   pipeline is empty. Reset loads key words 1, 2, 3, 4 and empties the
//   pipeline; it clears no payload.
//   When the receiver stalls with a response waiting, the whole pipeline
//   freezes and req_stall rises in the same cycle; nothing is dropped or
//   repeated. Bubbles in the pipeline do not collapse.
`default_nettype none

module tea_block_encrypt #(
   parameter int ROUND_COUNT = tea_pkg::ROUND_COUNT_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // request channel
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [tea_pkg::WORD_WIDTH-1:0]        req_plain_left,
   input  wire  [tea_pkg::WORD_WIDTH-1:0]        req_plain_right,
   // response channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [tea_pkg::WORD_WIDTH-1:0]        rsp_cipher_left,
   output logic [tea_pkg::WORD_WIDTH-1:0]        rsp_cipher_right,
   // configuration port
   input  wire                                   csr_write_enable,
   input  wire  [tea_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire  [tea_pkg::WORD_WIDTH-1:0]        csr_write_data
);
   import tea_pkg::*;

   localparam int STAGE_COUNT = 2 * ROUND_COUNT;

   word_type  key_0_ff, key_1_ff, key_2_ff, key_3_ff;
   logic      advance;
   stage_type stage [STAGE_COUNT+1];
   logic [STAGE_COUNT-1:0] valid_vector;

   // Key registers: plain write, no read-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_0_ff <= KEY_WORD_0_RESET;
         key_1_ff <= KEY_WORD_1_RESET;
         key_2_ff <= KEY_WORD_2_RESET;
         key_3_ff <= KEY_WORD_3_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_WORD_0: key_0_ff <= csr_write_data;
            CSR_KEY_WORD_1: key_1_ff <= csr_write_data;
            CSR_KEY_WORD_2: key_2_ff <= csr_write_data;
            CSR_KEY_WORD_3: key_3_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Freeze every stage only when a finished response is held by the receiver.
   assign advance   = !(stage[STAGE_COUNT].valid && rsp_stall);
   assign req_stall = !advance;

   assign stage[0] = '{valid: req_valid, left: req_plain_left, right: req_plain_right};

   // Even stage: left half from right half with key words 0/1.
   // Odd stage: right half from the new left half with key words 2/3.
   for (genvar i = 0; i < STAGE_COUNT; i++) begin : g_stage
      localparam bit UPDATE_RIGHT = (i % 2) == 1;

      tea_half_round #(
         .ROUND_SUM    (round_sum(i / 2)),
         .UPDATE_RIGHT (UPDATE_RIGHT)
      ) u_half_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (stage[i]),
         .key_a     (UPDATE_RIGHT ? key_2_ff : key_0_ff),
         .key_b     (UPDATE_RIGHT ? key_3_ff : key_1_ff),
         .stage_out (stage[i+1])
      );

      assign valid_vector[i] = stage[i+1].valid;
   end

   assign rsp_valid        = stage[STAGE_COUNT].valid;
   assign rsp_cipher_left  = stage[STAGE_COUNT].left;
   assign rsp_cipher_right = stage[STAGE_COUNT].right;

   // The request side stalls only behind a waiting response.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled response");

   // A frozen pipeline keeps its occupancy pattern.
   a_frozen_valids: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_vector))
      else $error("valid bits moved while the pipeline was frozen");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_vector == '0))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

@@ hw/rtl/tea_half_round.sv @@
// One registered half-round of TEA: updates either the left or the right half.
// Depends on tea_pkg.
`default_nettype none

module tea_half_round #(
   parameter logic [31:0] ROUND_SUM    = 32'h0,
   parameter bit          UPDATE_RIGHT = 1'b0
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 advance,
   input  tea_pkg::stage_type  stage_in,
   input  tea_pkg::word_type   key_a,
   input  tea_pkg::word_type   key_b,
   output tea_pkg::stage_type  stage_out
);
   import tea_pkg::*;

   logic     valid_ff;
   word_type left_ff, left_in;
   word_type right_ff, right_in;

   always_comb begin
      left_in  = stage_in.left;
      right_in = stage_in.right;
      if (UPDATE_RIGHT) begin
         right_in = stage_in.right + tea_mix(stage_in.left, ROUND_SUM, key_a, key_b);
      end else begin
         left_in = stage_in.left + tea_mix(stage_in.right, ROUND_SUM, key_a, key_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
   end

   // Payload needs no reset; hold it while the pipeline is frozen.
   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign stage_out = '{valid: valid_ff, left: left_ff, right: right_ff};

endmodule

`default_nettype wire
